// File: rtl/core/srs_pkg.sv
// Shared types, codes and helpers for the stencil relaxation sweep block.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package srs_pkg;

  localparam int PAD_AW   = 14;
  localparam int INT_AW   = 12;
  localparam int TERM_AW  = 5;
  localparam int VAL_W    = 32;
  localparam int OFF_W    = 15;
  localparam int MAX_TERMS = 32;
  localparam int MAX_SIDE  = 16;

  typedef enum logic [2:0] {
    FN_WR_PAD  = 3'd0,
    FN_WR_SOL  = 3'd1,
    FN_WR_SRC  = 3'd2,
    FN_WR_TERM = 3'd3,
    FN_SWEEP   = 3'd4,
    FN_RD_SOL  = 3'd5,
    FN_RD_PAD  = 3'd6,
    FN_NONE    = 3'd7
  } func_t;

  typedef enum logic [1:0] {
    KIND_SOL  = 2'd0,
    KIND_PAD  = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_METHOD = 3'd0,
    REG_WEIGHT = 3'd1,
    REG_RECIP  = 3'd2,
    REG_SIZE_X = 3'd3,
    REG_SIZE_Y = 3'd4,
    REG_SIZE_Z = 3'd5,
    REG_HALO   = 3'd6,
    REG_TERMS  = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    SW_IDLE, SW_PLANE, SW_START, SW_POINT, SW_TRD, SW_TADR, SW_TMUL, SW_TACC,
    SW_SRD, SW_DIFF, SW_QMUL, SW_QSAT, SW_JMUL, SW_JSUM, SW_DONE
  } sweep_state_t;

  typedef struct packed {
    logic               method;
    logic [17:0]        weight;
    logic signed [31:0] recip;
    logic [4:0]         size_x;
    logic [4:0]         size_y;
    logic [4:0]         size_z;
    logic [2:0]         halo;
    logic [5:0]         term_count;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [PAD_AW-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic              re;
    logic [PAD_AW-1:0] raddr;
  } pad_req_t;

  typedef struct packed {
    logic              we;
    logic [INT_AW-1:0] waddr;
    logic [VAL_W-1:0]  wdata;
    logic              re;
    logic [INT_AW-1:0] raddr;
  } int_req_t;

  typedef struct packed {
    logic               we;
    logic [TERM_AW-1:0] waddr;
    logic [VAL_W-1:0]   wweight;
    logic [OFF_W-1:0]   woffset;
    logic               re;
    logic [TERM_AW-1:0] raddr;
  } term_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sweep_stat_t;

  // Saturate a wide signed value to the word range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sh0000_0000_7FFF_FFFF;
    lo = -64'sh0000_0000_8000_0000;
    if (v > hi) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[VAL_W-1:0];
    end
  endfunction

  // Clamp an axis size to the largest side
  function automatic logic [4:0] clamp_side(input logic [4:0] s);
    clamp_side = (s > 5'(MAX_SIDE)) ? 5'(MAX_SIDE) : s;
  endfunction

endpackage

// File: rtl/core/srs_mem.sv
// Grid and stencil term storage: padded, solution, source and term memories.
// Depends on srs_pkg for request types; one write and one registered read each.
`timescale 1ns / 1ps

module srs_mem (
  input  logic                clk,
  input  srs_pkg::pad_req_t   pad_req,
  input  srs_pkg::int_req_t   sol_req,
  input  srs_pkg::int_req_t   src_req,
  input  srs_pkg::term_req_t  term_req,
  output logic [31:0]         pad_rdata,
  output logic [31:0]         sol_rdata,
  output logic [31:0]         src_rdata,
  output logic [31:0]         term_weight,
  output logic [14:0]         term_offset
);

  logic [31:0] pad_mem  [2**srs_pkg::PAD_AW];
  logic [31:0] sol_mem  [2**srs_pkg::INT_AW];
  logic [31:0] src_mem  [2**srs_pkg::INT_AW];
  logic [46:0] term_mem [2**srs_pkg::TERM_AW];

  // Padded grid
  always_ff @(posedge clk) begin
    if (pad_req.we) begin
      pad_mem[pad_req.waddr] <= pad_req.wdata;
    end
    if (pad_req.re) begin
      pad_rdata <= pad_mem[pad_req.raddr];
    end
  end

  // Solution grid
  always_ff @(posedge clk) begin
    if (sol_req.we) begin
      sol_mem[sol_req.waddr] <= sol_req.wdata;
    end
    if (sol_req.re) begin
      sol_rdata <= sol_mem[sol_req.raddr];
    end
  end

  // Source grid
  always_ff @(posedge clk) begin
    if (src_req.we) begin
      src_mem[src_req.waddr] <= src_req.wdata;
    end
    if (src_req.re) begin
      src_rdata <= src_mem[src_req.raddr];
    end
  end

  // Stencil terms, coefficient and offset packed in one word
  always_ff @(posedge clk) begin
    if (term_req.we) begin
      term_mem[term_req.waddr] <= {term_req.woffset, term_req.wweight};
    end
    if (term_req.re) begin
      {term_offset, term_weight} <= term_mem[term_req.raddr];
    end
  end

endmodule

// File: rtl/core/srs_sweep.sv
// Sweep sequencer and datapath: walks interior points and terms, does the
// multiply-accumulate, relaxation update and write-back. Depends on srs_pkg.
`timescale 1ns / 1ps

module srs_sweep (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                done_ack,
  input  srs_pkg::cfg_t       cfg,
  input  logic [31:0]         pad_rdata,
  input  logic [31:0]         sol_rdata,
  input  logic [31:0]         src_rdata,
  input  logic [31:0]         term_weight,
  input  logic [14:0]         term_offset,
  output srs_pkg::pad_req_t   pad_req,
  output srs_pkg::int_req_t   sol_req,
  output srs_pkg::int_req_t   src_req,
  output srs_pkg::term_req_t  term_req,
  output srs_pkg::sweep_stat_t stat
);

  srs_pkg::sweep_state_t state_r, state_nxt;

  logic [4:0]  nx_r, ny_r, nz_r;
  logic [4:0]  p2_r;
  logic [9:0]  plane_r;
  logic [5:0]  terms_r;
  logic [4:0]  i0_r, i1_r, i2_r;
  logic [13:0] centre_r;
  logic [13:0] row_step_r, plane_step_r;
  logic [11:0] si_r;
  logic [5:0]  c_r;
  logic [31:0] weight_r;
  logic signed [63:0] prod_r;
  logic signed [53:0] acc_r;
  logic signed [31:0] diff_r, old_r, q_r;
  logic signed [50:0] m1_r, m2_r;

  logic last0, last1, last2, last_pt, more_terms;
  logic [13:0] nbr_addr;
  logic signed [31:0] q_now, j_new;
  logic signed [63:0] diff_wide, jsum;
  logic signed [18:0] keep;
  logic [4:0] p1;

  assign last2      = (i2_r == nz_r - 5'd1);
  assign last1      = (i1_r == ny_r - 5'd1);
  assign last0      = (i0_r == nx_r - 5'd1);
  assign last_pt    = last0 && last1 && last2;
  assign more_terms = ((c_r + 6'd1) < terms_r);
  assign nbr_addr   = centre_r + term_offset[13:0];
  assign p1         = ny_r + {1'b0, cfg.halo, 1'b0};
  assign diff_wide  = 64'($signed(src_rdata)) - 64'(acc_r);
  assign q_now      = srs_pkg::sat32(prod_r >>> 16);
  assign keep       = 19'sh10000 - $signed({1'b0, cfg.weight});
  assign jsum       = 64'(m1_r) + 64'(m2_r);
  assign j_new      = srs_pkg::sat32(jsum >>> 16);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      srs_pkg::SW_IDLE:  if (start) state_nxt = srs_pkg::SW_PLANE;
      srs_pkg::SW_PLANE: state_nxt = srs_pkg::SW_START;
      srs_pkg::SW_START: begin
        if (nx_r == 5'd0 || ny_r == 5'd0 || nz_r == 5'd0) begin
          state_nxt = srs_pkg::SW_DONE;
        end else begin
          state_nxt = srs_pkg::SW_POINT;
        end
      end
      srs_pkg::SW_POINT: begin
        if (terms_r > 6'd1) begin
          state_nxt = srs_pkg::SW_TRD;
        end else begin
          state_nxt = srs_pkg::SW_SRD;
        end
      end
      srs_pkg::SW_TRD:  state_nxt = srs_pkg::SW_TADR;
      srs_pkg::SW_TADR: state_nxt = srs_pkg::SW_TMUL;
      srs_pkg::SW_TMUL: state_nxt = srs_pkg::SW_TACC;
      srs_pkg::SW_TACC: begin
        if (more_terms) begin
          state_nxt = srs_pkg::SW_TRD;
        end else begin
          state_nxt = srs_pkg::SW_SRD;
        end
      end
      srs_pkg::SW_SRD:  state_nxt = srs_pkg::SW_DIFF;
      srs_pkg::SW_DIFF: state_nxt = srs_pkg::SW_QMUL;
      srs_pkg::SW_QMUL: state_nxt = srs_pkg::SW_QSAT;
      srs_pkg::SW_QSAT: begin
        if (!cfg.method) begin
          state_nxt = srs_pkg::SW_JMUL;
        end else if (last_pt) begin
          state_nxt = srs_pkg::SW_DONE;
        end else begin
          state_nxt = srs_pkg::SW_POINT;
        end
      end
      srs_pkg::SW_JMUL: state_nxt = srs_pkg::SW_JSUM;
      srs_pkg::SW_JSUM: begin
        if (last_pt) begin
          state_nxt = srs_pkg::SW_DONE;
        end else begin
          state_nxt = srs_pkg::SW_POINT;
        end
      end
      srs_pkg::SW_DONE: if (done_ack) state_nxt = srs_pkg::SW_IDLE;
      default:          state_nxt = srs_pkg::SW_IDLE;
    endcase
  end

  // Memory requests and status
  always_comb begin
    pad_req  = '0;
    sol_req  = '0;
    src_req  = '0;
    term_req = '0;
    stat.busy = (state_r != srs_pkg::SW_IDLE);
    stat.done = (state_r == srs_pkg::SW_DONE);
    unique case (state_r)
      srs_pkg::SW_TRD: begin
        term_req.re    = 1'b1;
        term_req.raddr = c_r[4:0];
      end
      srs_pkg::SW_TADR: begin
        pad_req.re    = 1'b1;
        pad_req.raddr = nbr_addr;
      end
      srs_pkg::SW_SRD: begin
        src_req.re    = 1'b1;
        src_req.raddr = si_r;
        sol_req.re    = 1'b1;
        sol_req.raddr = si_r;
      end
      srs_pkg::SW_QSAT: begin
        if (cfg.method) begin
          sol_req.we    = 1'b1;
          sol_req.waddr = si_r;
          sol_req.wdata = q_now;
          pad_req.we    = 1'b1;
          pad_req.waddr = centre_r;
          pad_req.wdata = q_now;
        end
      end
      srs_pkg::SW_JSUM: begin
        sol_req.we    = 1'b1;
        sol_req.waddr = si_r;
        sol_req.wdata = j_new;
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= srs_pkg::SW_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    logic adv;
    adv = (state_r == srs_pkg::SW_JSUM) ||
          (state_r == srs_pkg::SW_QSAT && cfg.method);
    unique case (state_r)
      srs_pkg::SW_IDLE: begin
        nx_r    <= srs_pkg::clamp_side(cfg.size_x);
        ny_r    <= srs_pkg::clamp_side(cfg.size_y);
        nz_r    <= srs_pkg::clamp_side(cfg.size_z);
        terms_r <= (cfg.term_count > 6'(srs_pkg::MAX_TERMS)) ?
                   6'(srs_pkg::MAX_TERMS) : cfg.term_count;
      end
      srs_pkg::SW_PLANE: begin
        p2_r    <= nz_r + {1'b0, cfg.halo, 1'b0};
        plane_r <= 10'(p1 * (nz_r + {1'b0, cfg.halo, 1'b0}));
      end
      srs_pkg::SW_START: begin
        centre_r     <= 14'(cfg.halo * plane_r) + 14'(cfg.halo * p2_r) + 14'(cfg.halo);
        row_step_r   <= 14'({cfg.halo, 1'b0}) + 14'd1;
        plane_step_r <= 14'({cfg.halo, 1'b0} * p2_r) + 14'({cfg.halo, 1'b0}) + 14'd1;
        i0_r <= '0;
        i1_r <= '0;
        i2_r <= '0;
        si_r <= '0;
      end
      srs_pkg::SW_POINT: begin
        acc_r <= '0;
        c_r   <= 6'd1;
      end
      srs_pkg::SW_TADR: weight_r <= term_weight;
      srs_pkg::SW_TMUL: prod_r   <= $signed(pad_rdata) * $signed(weight_r);
      srs_pkg::SW_TACC: begin
        acc_r <= acc_r + 54'(prod_r >>> 16);
        c_r   <= c_r + 6'd1;
      end
      srs_pkg::SW_DIFF: begin
        diff_r <= srs_pkg::sat32(diff_wide);
        old_r  <= $signed(sol_rdata);
      end
      srs_pkg::SW_QMUL: prod_r <= diff_r * cfg.recip;
      srs_pkg::SW_QSAT: q_r    <= q_now;
      srs_pkg::SW_JMUL: begin
        m1_r <= keep * old_r;
        m2_r <= $signed({1'b0, cfg.weight}) * q_r;
      end
      default: ;
    endcase
    // Step to the next interior point
    if (adv) begin
      si_r <= si_r + 12'd1;
      if (!last2) begin
        i2_r     <= i2_r + 5'd1;
        centre_r <= centre_r + 14'd1;
      end else if (!last1) begin
        i2_r     <= '0;
        i1_r     <= i1_r + 5'd1;
        centre_r <= centre_r + row_step_r;
      end else begin
        i2_r     <= '0;
        i1_r     <= '0;
        i0_r     <= i0_r + 5'd1;
        centre_r <= centre_r + plane_step_r;
      end
    end
  end

endmodule

// File: rtl/core/stencil_relaxation_sweep.sv
// A load is written when accepted; a read returns its word via the memory and output
// registers. Loads and reads one per cycle unless a sweep runs or a read waits on a
// stalled output. A sweep walks PLANE, START, then for each interior point POINT,
// TRD/TADR/TMUL/TACC per clamped term after the first, SRD, DIFF, QMUL, QSAT, and for
// weighted Jacobi JMUL, JSUM; finish reported in one transaction. Reset (synchronous,
// rst_n low) clears control and configuration; memories stay undefined until written.
`timescale 1ns / 1ps

module stencil_relaxation_sweep (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [13:0] in_address,
  input  logic signed [31:0] in_value,
  input  logic signed [14:0] in_term_offset,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic signed [31:0] out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  srs_pkg::cfg_t       cfg_r;
  srs_pkg::pad_req_t   host_pad, sw_pad, pad_req;
  srs_pkg::int_req_t   host_sol, sw_sol, sol_req;
  srs_pkg::int_req_t   host_src, sw_src, src_req;
  srs_pkg::term_req_t  host_term, sw_term, term_req;
  srs_pkg::sweep_stat_t stat;
  srs_pkg::func_t      func;

  logic [31:0] pad_rdata, sol_rdata, src_rdata, term_weight;
  logic [14:0] term_offset;
  logic        rd_pend_r, rd_pad_r;
  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [31:0] out_data_r;
  logic        out_free, xfer, accept, done_ack, cfg_wr;

  assign func     = srs_pkg::func_t'(in_func);
  assign out_free = !out_valid_r || !out_stall;
  assign xfer     = rd_pend_r && out_free;
  assign in_stall = stat.busy || (rd_pend_r && !xfer);
  assign accept   = in_valid && !in_stall;
  assign done_ack = stat.done && !rd_pend_r && out_free;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;

  // Decode host transactions into memory requests
  always_comb begin
    host_pad  = '0;
    host_sol  = '0;
    host_src  = '0;
    host_term = '0;
    host_pad.waddr  = in_address;
    host_pad.wdata  = in_value;
    host_pad.raddr  = in_address;
    host_sol.waddr  = in_address[11:0];
    host_sol.wdata  = in_value;
    host_sol.raddr  = in_address[11:0];
    host_src.waddr  = in_address[11:0];
    host_src.wdata  = in_value;
    host_term.waddr   = in_address[4:0];
    host_term.wweight = in_value;
    host_term.woffset = in_term_offset;
    if (accept) begin
      unique case (func)
        srs_pkg::FN_WR_PAD:  host_pad.we  = 1'b1;
        srs_pkg::FN_WR_SOL:  host_sol.we  = 1'b1;
        srs_pkg::FN_WR_SRC:  host_src.we  = 1'b1;
        srs_pkg::FN_WR_TERM: host_term.we = 1'b1;
        srs_pkg::FN_RD_SOL:  host_sol.re  = 1'b1;
        srs_pkg::FN_RD_PAD:  host_pad.re  = 1'b1;
        default: ;
      endcase
    end
  end

  // Hand the memories to the sweep while it runs
  assign pad_req  = stat.busy ? sw_pad  : host_pad;
  assign sol_req  = stat.busy ? sw_sol  : host_sol;
  assign src_req  = stat.busy ? sw_src  : host_src;
  assign term_req = stat.busy ? sw_term : host_term;

  srs_mem u_mem (
    .clk         (clk),
    .pad_req     (pad_req),
    .sol_req     (sol_req),
    .src_req     (src_req),
    .term_req    (term_req),
    .pad_rdata   (pad_rdata),
    .sol_rdata   (sol_rdata),
    .src_rdata   (src_rdata),
    .term_weight (term_weight),
    .term_offset (term_offset)
  );

  srs_sweep u_sweep (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (accept && func == srs_pkg::FN_SWEEP),
    .done_ack    (done_ack),
    .cfg         (cfg_r),
    .pad_rdata   (pad_rdata),
    .sol_rdata   (sol_rdata),
    .src_rdata   (src_rdata),
    .term_weight (term_weight),
    .term_offset (term_offset),
    .pad_req     (sw_pad),
    .sol_req     (sw_sol),
    .src_req     (sw_src),
    .term_req    (sw_term),
    .stat        (stat)
  );

  // Track the read in flight and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && (func == srs_pkg::FN_RD_SOL || func == srs_pkg::FN_RD_PAD)) begin
        rd_pend_r <= 1'b1;
      end else if (xfer) begin
        rd_pend_r <= 1'b0;
      end
      if (xfer || done_ack) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_pad_r <= (func == srs_pkg::FN_RD_PAD);
    end
    if (xfer) begin
      out_kind_r <= rd_pad_r ? srs_pkg::KIND_PAD : srs_pkg::KIND_SOL;
      out_data_r <= rd_pad_r ? pad_rdata : sol_rdata;
    end else if (done_ack) begin
      out_kind_r <= srs_pkg::KIND_DONE;
      out_data_r <= '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_data  = out_data_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.method     <= 1'b1;
      cfg_r.weight     <= 18'd65536;
      cfg_r.recip      <= 32'sd65536;
      cfg_r.size_x     <= 5'd16;
      cfg_r.size_y     <= 5'd16;
      cfg_r.size_z     <= 5'd16;
      cfg_r.halo       <= 3'd1;
      cfg_r.term_count <= 6'd7;
    end else if (cfg_wr) begin
      unique case (srs_pkg::reg_idx_t'(paddr[4:2]))
        srs_pkg::REG_METHOD: cfg_r.method     <= pwdata[0];
        srs_pkg::REG_WEIGHT: cfg_r.weight     <= pwdata[17:0];
        srs_pkg::REG_RECIP:  cfg_r.recip      <= pwdata;
        srs_pkg::REG_SIZE_X: cfg_r.size_x     <= pwdata[4:0];
        srs_pkg::REG_SIZE_Y: cfg_r.size_y     <= pwdata[4:0];
        srs_pkg::REG_SIZE_Z: cfg_r.size_z     <= pwdata[4:0];
        srs_pkg::REG_HALO:   cfg_r.halo       <= pwdata[2:0];
        srs_pkg::REG_TERMS:  cfg_r.term_count <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    unique case (srs_pkg::reg_idx_t'(paddr[4:2]))
      srs_pkg::REG_METHOD: prdata = {31'd0, cfg_r.method};
      srs_pkg::REG_WEIGHT: prdata = {14'd0, cfg_r.weight};
      srs_pkg::REG_RECIP:  prdata = cfg_r.recip;
      srs_pkg::REG_SIZE_X: prdata = {27'd0, cfg_r.size_x};
      srs_pkg::REG_SIZE_Y: prdata = {27'd0, cfg_r.size_y};
      srs_pkg::REG_SIZE_Z: prdata = {27'd0, cfg_r.size_z};
      srs_pkg::REG_HALO:   prdata = {29'd0, cfg_r.halo};
      srs_pkg::REG_TERMS:  prdata = {26'd0, cfg_r.term_count};
      default:             prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/srs_checker.sv
// Port-level checks for the stencil relaxation sweep top level.
// Depends on srs_pkg codes; bound to stencil_relaxation_sweep below.
`timescale 1ns / 1ps

module srs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  in_func,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_kind,
  input logic [31:0] out_data
);

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_data))
    else $error("stalled result changed");

  // Finish report carries zero data
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == srs_pkg::KIND_DONE |-> out_data == 32'd0)
    else $error("sweep finish with nonzero data");

  // Block input while a sweep runs
  a_sweep_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func == srs_pkg::FN_SWEEP |=> in_stall)
    else $error("input taken during sweep");

  // Deliver read data through the memory and output registers into an empty output
  a_read_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid &&
    (in_func == srs_pkg::FN_RD_SOL || in_func == srs_pkg::FN_RD_PAD) |=> ##1 out_valid)
    else $error("read result missing");

endmodule

bind stencil_relaxation_sweep srs_checker u_srs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_func   (in_func),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_kind  (out_kind),
  .out_data  (out_data)
);

// File: tb/sv/tb.sv
// Testbench for stencil_relaxation_sweep: grid loads, reads and relaxation sweeps.
// Depends on srs_pkg and the RTL top level; predicts every result and checks it in order.
`timescale 1ns / 1ps

module tb;

  typedef struct {
    logic [2:0]  func;
    logic [13:0] addr;
    logic [31:0] val;
    logic [14:0] off;
  } op_t;

  typedef struct {
    srs_pkg::kind_t kind;
    logic [31:0]    data;
  } reply_t;

  typedef struct {
    logic [2:0]     func;
    logic [13:0]    addr;
    logic [31:0]    val;
    logic [14:0]    off;
    bit             typed;
    srs_pkg::kind_t kind;
    logic [31:0]    data;
  } dir_row_t;

  localparam int PAD_WORDS_T = 16384;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_func;
  logic [13:0] in_address;
  logic signed [31:0] in_value;
  logic signed [14:0] in_term_offset;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_kind;
  logic signed [31:0] out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  stencil_relaxation_sweep DUT (.*);

  // Shadow state of the block
  longint pad_mem [PAD_WORDS_T];
  longint sol_mem [4096];
  longint src_mem [4096];
  longint coef_mem [32];
  longint offs_mem [32];
  bit     pad_ok [16384];
  bit     sol_ok [4096];
  bit     src_ok [4096];
  bit     term_ok [32];
  int     pad_list [$];
  int     sol_list [$];

  logic        sh_method;
  logic [17:0] sh_weight;
  longint      sh_recip;
  logic [4:0]  sh_sx, sh_sy, sh_sz;
  logic [2:0]  sh_halo;
  logic [5:0]  sh_terms;

  reply_t replies_due [$];
  int     errors;
  int     op_count;
  bit     quiet;

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic int wrap_pad(longint a);
    return int'(((a % 16384) + 16384) % 16384);
  endfunction

  // Sweep geometry under the current settings
  function automatic void geometry(output int nx, output int ny, output int nz,
                                   output int p1, output int p2, output int nt,
                                   output longint start);
    nx = (sh_sx > 16) ? 16 : sh_sx;
    ny = (sh_sy > 16) ? 16 : sh_sy;
    nz = (sh_sz > 16) ? 16 : sh_sz;
    nt = (sh_terms > 32) ? 32 : sh_terms;
    p2 = nz + 2 * sh_halo;
    p1 = ny + 2 * sh_halo;
    start = longint'(sh_halo) * p1 * p2 + sh_halo * p2 + sh_halo;
  endfunction

  // One relaxation pass over the shadow grids
  function automatic void relax_pass();
    int nx, ny, nz, p1, p2, nt, idx, si;
    longint start, centre, total, diff, q, mix;
    geometry(nx, ny, nz, p1, p2, nt, start);
    idx = 0;
    for (int i0 = 0; i0 < nx; i0++)
      for (int i1 = 0; i1 < ny; i1++)
        for (int i2 = 0; i2 < nz; i2++) begin
          centre = start + longint'(i0) * p1 * p2 + i1 * p2 + i2;
          si = idx % 4096;
          total = 0;
          for (int c = 1; c < nt; c++)
            total += (pad_mem[wrap_pad(centre + offs_mem[c])] * coef_mem[c]) >>> 16;
          diff = clip32(src_mem[si] - total);
          q = clip32((diff * sh_recip) >>> 16);
          if (sh_method) begin
            sol_mem[si] = q;
            pad_mem[wrap_pad(centre)] = q;
            pad_ok[wrap_pad(centre)] = 1'b1;
          end else begin
            mix = (65536 - longint'(sh_weight)) * sol_mem[si] + longint'(sh_weight) * q;
            sol_mem[si] = clip32(mix >>> 16);
          end
          sol_ok[si] = 1'b1;
          idx++;
        end
  endfunction

  // Apply one accepted transaction to the shadow state, queue its result
  task automatic predict(op_t op, bit typed, srs_pkg::kind_t tk, logic [31:0] td);
    reply_t r;
    bit     has;
    longint v;
    has = 1'b0;
    v = longint'(signed'(op.val));
    case (srs_pkg::func_t'(op.func))
      srs_pkg::FN_WR_PAD: begin
        pad_mem[op.addr] = v;
        if (!pad_ok[op.addr]) pad_list.push_back(op.addr);
        pad_ok[op.addr] = 1'b1;
      end
      srs_pkg::FN_WR_SOL: begin
        sol_mem[op.addr % 4096] = v;
        if (!sol_ok[op.addr % 4096]) sol_list.push_back(op.addr % 4096);
        sol_ok[op.addr % 4096] = 1'b1;
      end
      srs_pkg::FN_WR_SRC: begin
        src_mem[op.addr % 4096] = v;
        src_ok[op.addr % 4096] = 1'b1;
      end
      srs_pkg::FN_WR_TERM: begin
        coef_mem[op.addr % 32] = v;
        offs_mem[op.addr % 32] = longint'(signed'(op.off));
        term_ok[op.addr % 32] = 1'b1;
      end
      srs_pkg::FN_SWEEP: begin
        relax_pass();
        has = 1'b1; r.kind = srs_pkg::KIND_DONE; r.data = '0;
      end
      srs_pkg::FN_RD_SOL: begin
        has = 1'b1; r.kind = srs_pkg::KIND_SOL; r.data = sol_mem[op.addr % 4096][31:0];
      end
      srs_pkg::FN_RD_PAD: begin
        has = 1'b1; r.kind = srs_pkg::KIND_PAD; r.data = pad_mem[op.addr][31:0];
      end
      default: ;
    endcase
    if (has) begin
      if (typed) begin
        r.kind = tk;
        r.data = td;
      end
      replies_due.push_back(r);
    end
  endtask

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected result kind", out_kind, 0);
      end else begin
        want = replies_due.pop_front();
        if (out_kind !== want.kind) report_mismatch("kind", out_kind, want.kind);
        if (out_data !== want.data) report_mismatch("data", out_data, want.data);
      end
    end
  end

  // Result-side stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall = 1'b0;
      end else if ($urandom_range(0, 30) == 0) begin
        repeat (40) @(negedge clk);
      end
    end
  end

  // Drive one transaction and wait until it is taken
  task automatic drive_op(op_t op, bit typed, srs_pkg::kind_t tk, logic [31:0] td);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_func = op.func;
    in_address = op.addr;
    in_value = op.val;
    in_term_offset = op.off;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predict(op, typed, tk, td);
    if (op.func != srs_pkg::FN_NONE) op_count++;
  endtask

  function automatic logic [31:0] rand_word();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h60000)) - 32'sh30000);
  endfunction

  function automatic logic [31:0] rand_coef();
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h8000)) - 32'sh4000);
  endfunction

  // Load every entry the next sweep touches that has not been loaded yet
  task automatic prime_sweep();
    int nx, ny, nz, p1, p2, nt, idx, si, na;
    longint start, centre;
    op_t op;
    geometry(nx, ny, nz, p1, p2, nt, start);
    for (int c = 1; c < nt; c++)
      if (!term_ok[c]) begin
        op.func = srs_pkg::FN_WR_TERM; op.addr = 14'(c); op.val = rand_coef();
        case ($urandom_range(0, 3))
          0: op.off = 15'($urandom_range(0, 2) - 1);
          1: op.off = 15'(($urandom_range(0, 1) ? 1 : -1) * p2);
          2: op.off = 15'(($urandom_range(0, 1) ? 1 : -1) * p1 * p2);
          default: op.off = 15'($urandom);
        endcase
        drive_op(op, 1'b0, srs_pkg::KIND_DONE, '0);
      end
    idx = 0;
    for (int i0 = 0; i0 < nx; i0++)
      for (int i1 = 0; i1 < ny; i1++)
        for (int i2 = 0; i2 < nz; i2++) begin
          centre = start + longint'(i0) * p1 * p2 + i1 * p2 + i2;
          si = idx % 4096;
          for (int c = 1; c < nt; c++) begin
            na = wrap_pad(centre + offs_mem[c]);
            if (!pad_ok[na]) begin
              op.func = srs_pkg::FN_WR_PAD; op.addr = 14'(na); op.val = rand_word();
              op.off = '0;
              drive_op(op, 1'b0, srs_pkg::KIND_DONE, '0);
            end
          end
          if (!src_ok[si]) begin
            op.func = srs_pkg::FN_WR_SRC; op.addr = 14'(si); op.val = rand_word();
            drive_op(op, 1'b0, srs_pkg::KIND_DONE, '0);
          end
          if (!sh_method && !sol_ok[si]) begin
            op.func = srs_pkg::FN_WR_SOL; op.addr = 14'(si); op.val = rand_word();
            drive_op(op, 1'b0, srs_pkg::KIND_DONE, '0);
          end
          idx++;
        end
  endtask

  task automatic issue(op_t op, bit typed, srs_pkg::kind_t tk, logic [31:0] td);
    if (op.func == srs_pkg::FN_SWEEP) prime_sweep();
    drive_op(op, typed, tk, td);
  endtask

  // Hold off until the block has drained
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Register write with a setup phase and an access phase
  task automatic cfg_write(srs_pkg::reg_idx_t idx, logic [31:0] v);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = 5'(4 * idx); pwdata = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      srs_pkg::REG_METHOD: sh_method = v[0];
      srs_pkg::REG_WEIGHT: sh_weight = v[17:0];
      srs_pkg::REG_RECIP:  sh_recip = longint'(signed'(v));
      srs_pkg::REG_SIZE_X: sh_sx = v[4:0];
      srs_pkg::REG_SIZE_Y: sh_sy = v[4:0];
      srs_pkg::REG_SIZE_Z: sh_sz = v[4:0];
      srs_pkg::REG_HALO:   sh_halo = v[2:0];
      srs_pkg::REG_TERMS:  sh_terms = v[5:0];
      default: ;
    endcase
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  task automatic set_all(logic m, logic [17:0] w, logic [31:0] rc, logic [4:0] x,
                         logic [4:0] y, logic [4:0] z, logic [2:0] h, logic [5:0] t);
    cfg_write(srs_pkg::REG_METHOD, 32'(m));
    cfg_write(srs_pkg::REG_WEIGHT, 32'(w));
    cfg_write(srs_pkg::REG_RECIP, rc);
    cfg_write(srs_pkg::REG_SIZE_X, 32'(x));
    cfg_write(srs_pkg::REG_SIZE_Y, 32'(y));
    cfg_write(srs_pkg::REG_SIZE_Z, 32'(z));
    cfg_write(srs_pkg::REG_HALO, 32'(h));
    cfg_write(srs_pkg::REG_TERMS, 32'(t));
  endtask

  // Directed rows: extremes, wraps, every function code
  dir_row_t dir_rows [18] = '{
    '{srs_pkg::FN_WR_PAD,  14'd0,     32'h7FFF_FFFF, 15'd0,    1'b0, srs_pkg::KIND_DONE,
      32'h0},
    '{srs_pkg::FN_RD_PAD,  14'd0,     32'h0,         15'd0,    1'b1, srs_pkg::KIND_PAD,
      32'h7FFF_FFFF},
    '{srs_pkg::FN_WR_PAD,  14'd16383, 32'h8000_0000, 15'd0,    1'b0, srs_pkg::KIND_DONE,
      32'h0},
    '{srs_pkg::FN_RD_PAD,  14'd16383, 32'h0,         15'd0,    1'b1, srs_pkg::KIND_PAD,
      32'h8000_0000},
    '{srs_pkg::FN_WR_SOL,  14'd4095,  32'hFFFF_FFFF, 15'd0,    1'b0, srs_pkg::KIND_DONE,
      32'h0},
    '{srs_pkg::FN_RD_SOL,  14'd16383, 32'h0,         15'd0,    1'b1, srs_pkg::KIND_SOL,
      32'hFFFF_FFFF},
    '{srs_pkg::FN_WR_SOL,  14'd4101,  32'h0000_3039, 15'd0,    1'b0, srs_pkg::KIND_DONE,
      32'h0},
    '{srs_pkg::FN_RD_SOL,  14'd5,     32'h0,         15'd0,    1'b1, srs_pkg::KIND_SOL,
      32'h0000_3039},
    '{srs_pkg::FN_WR_SRC,  14'd8191,  32'h0001_0000, 15'd0,    1'b0, srs_pkg::KIND_DONE,
      32'h0},
    '{srs_pkg::FN_WR_TERM, 14'd33,    32'h0001_0000, 15'h4001, 1'b0, srs_pkg::KIND_DONE,
      32'h0},
    '{srs_pkg::FN_WR_TERM, 14'd31,    32'h8000_0000, 15'h3FFF, 1'b0, srs_pkg::KIND_DONE,
      32'h0},
    '{srs_pkg::FN_WR_TERM, 14'd0,     32'h0000_0007, 15'h3FFF, 1'b0, srs_pkg::KIND_DONE,
      32'h0},
    '{srs_pkg::FN_NONE,    14'd16383, 32'hFFFF_FFFF, 15'h7FFF, 1'b0, srs_pkg::KIND_DONE,
      32'h0},
    '{srs_pkg::FN_SWEEP,   14'd0,     32'h0,         15'd0,    1'b1, srs_pkg::KIND_DONE,
      32'h0},
    '{srs_pkg::FN_RD_SOL,  14'd0,     32'h0,         15'd0,    1'b0, srs_pkg::KIND_DONE,
      32'h0},
    '{srs_pkg::FN_RD_PAD,  14'd22,    32'h0,         15'd0,    1'b0, srs_pkg::KIND_DONE,
      32'h0},
    '{srs_pkg::FN_SWEEP,   14'd16383, 32'hFFFF_FFFF, 15'h7FFF, 1'b1, srs_pkg::KIND_DONE,
      32'h0},
    '{srs_pkg::FN_RD_SOL,  14'd1,     32'h0,         15'd0,    1'b0, srs_pkg::KIND_DONE,
      32'h0}
  };

  // Random transactions under the current settings
  task automatic random_phase(int n);
    op_t op;
    int  r, nx, ny, nz, p1, p2, nt;
    longint start;
    geometry(nx, ny, nz, p1, p2, nt, start);
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      op.addr = 14'($urandom); op.val = rand_word(); op.off = 15'($urandom);
      if (r < 25) begin
        op.func = srs_pkg::FN_WR_PAD;
        if ($urandom_range(0, 4) != 0)
          op.addr = 14'($urandom_range(0, (nx + 2 * sh_halo) * p1 * p2));
      end else if (r < 35) begin
        op.func = srs_pkg::FN_WR_SOL;
      end else if (r < 45) begin
        op.func = srs_pkg::FN_WR_SRC;
        if ($urandom_range(0, 1)) op.addr = 14'($urandom_range(0, 63));
      end else if (r < 52) begin
        op.func = srs_pkg::FN_WR_TERM;
        op.val = rand_coef();
        if ($urandom_range(0, 2) != 0) op.off = 15'($urandom_range(0, 2) - 1);
      end else if (r < 58) begin
        op.func = srs_pkg::FN_SWEEP;
      end else if (r < 78) begin
        if (sol_list.size() == 0) continue;
        op.func = srs_pkg::FN_RD_SOL;
        op.addr = 14'(sol_list[$urandom_range(0, sol_list.size() - 1)])
                | 14'($urandom_range(0, 3) << 12);
      end else if (r < 96) begin
        if (pad_list.size() == 0) continue;
        op.func = srs_pkg::FN_RD_PAD;
        op.addr = 14'(pad_list[$urandom_range(0, pad_list.size() - 1)]);
      end else begin
        op.func = srs_pkg::FN_NONE;
      end
      issue(op, 1'b0, srs_pkg::KIND_DONE, '0);
      if (op_count > 1450) quiet = 1'b1;
    end
  endtask

  initial begin
    op_t         op;
    int          base, pick;
    logic [17:0] w;
    logic [31:0] rc;
    logic [4:0]  sx, sy, sz;
    logic [5:0]  tc;
    errors = 0; op_count = 0; quiet = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_func = '0; in_address = '0; in_value = '0; in_term_offset = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    sh_method = 1'b1; sh_weight = 18'd65536; sh_recip = 65536;
    sh_sx = 5'd16; sh_sy = 5'd16; sh_sz = 5'd16; sh_halo = 3'd1; sh_terms = 6'd7;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed part: small Gauss-Seidel grid, then an empty sweep and a weighted Jacobi sweep
    set_all(1'b1, 18'd65536, 32'h0000_4000, 5'd2, 5'd1, 5'd3, 3'd1, 6'd3);
    foreach (dir_rows[i]) begin
      op.func = dir_rows[i].func; op.addr = dir_rows[i].addr;
      op.val = dir_rows[i].val; op.off = dir_rows[i].off;
      issue(op, dir_rows[i].typed, dir_rows[i].kind, dir_rows[i].data);
      if (i == 13) begin
        drain();
        set_all(1'b0, 18'd0, 32'h8000_0000, 5'd0, 5'd2, 5'd2, 3'd0, 6'd0);
      end
    end
    drain();
    set_all(1'b0, 18'd131072, 32'h7FFF_FFFF, 5'd16, 5'd1, 5'd1, 3'd4, 6'd32);
    op.func = srs_pkg::FN_SWEEP; op.addr = '0; op.val = '0; op.off = '0;
    issue(op, 1'b0, srs_pkg::KIND_DONE, '0);
    drain();

    // Random phases with random settings
    while (op_count < 1600) begin
      pick = $urandom_range(0, 3);
      w  = (pick == 0) ? 18'd0 : (pick == 1) ? 18'd131072 :
           ($urandom_range(0, 9) == 0) ? 18'h3FFFF : 18'($urandom_range(0, 131072));
      rc = ($urandom_range(0, 4) == 0) ? $urandom
         : 32'($signed($urandom_range(0, 32'h30000)) - 32'sh18000);
      sx = 5'($urandom_range(1, 4)); sy = 5'($urandom_range(1, 4));
      sz = 5'($urandom_range(1, 4));
      base = $urandom_range(0, 19);
      if (base == 0) begin
        sx = 5'd1; sy = 5'($urandom_range(16, 31)); sz = 5'd1;
      end else if (base == 1) begin
        sz = 5'd16; sy = 5'd2; sx = 5'd1;
      end else if (base == 2) begin
        sx = 5'd0;
      end
      pick = $urandom_range(0, 15);
      tc = (pick == 0) ? 6'd0 : (pick == 1) ? 6'd32 : (pick == 2) ? 6'd63 :
           6'($urandom_range(1, 8));
      if ((sx * sy * sz > 16) && tc > 8) tc = 6'd8;
      set_all(1'($urandom_range(0, 1)), w, rc, sx, sy, sz, 3'($urandom_range(0, 4)), tc);
      random_phase($urandom_range(10, 60));
      drain();
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
